@@ design/s2i_pkg.sv @@
// ============================================================================
// s2i_pkg
// Shared types and constants of the string to integer parser.
// ============================================================================
package s2i_pkg;

    // Number of alphabet symbols that the parser can look up
    localparam int MAX_SYMBOLS = 16;
    localparam int SYM_W       = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

    localparam int CHAR_W    = 8;
    localparam int VALUE_W   = 32;
    localparam int ALPHA_W   = 64;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN   = CFG_IDX_W'(2);

    // Character codes
    localparam logic [CHAR_W-1:0] CH_PLUS      = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS     = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
    localparam logic [CHAR_W-1:0] CH_CTRL_MAX  = 8'd31;
    localparam logic [CHAR_W-1:0] CH_ASCII_TOP = 8'd128;

    typedef enum logic [1:0] {
        PH_BLANKS = 2'd0,
        PH_SIGNS  = 2'd1,
        PH_DIGITS = 2'd2,
        PH_STOP   = 2'd3
    } phase_t;

endpackage

@@ design/s2i_if.sv @@
// ============================================================================
// s2i_if
// Valid/ready channels of the string to integer parser.
// ============================================================================

// Character stream: one byte of the string per beat
interface s2i_text_if
    import s2i_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              end_of_string;

    modport source (output valid, output character, output end_of_string, input ready);
    modport sink   (input valid, input character, input end_of_string, output ready);
endinterface

// Result stream: one parsed number per string
interface s2i_result_if
    import s2i_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      alphabet_valid;

    modport source (output valid, output value, output alphabet_valid, input ready);
    modport sink   (input valid, input value, input alphabet_valid, output ready);
endinterface

// Configuration write channel
interface s2i_cfg_if
    import s2i_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ALPHA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/string_to_int_any_base.sv @@
// ============================================================================
// string_to_int_any_base
// Parses a character stream into a signed integer in a configurable base.
// ============================================================================
// Usage:
//   cfg    : write beats set alphabet_low (index 0), alphabet_high (index 1)
//            and base_length (index 2). Always ready. Write only while idle.
//   text   : one byte per beat; end_of_string marks the last byte of a string.
//   result : one beat per string, issued for the end_of_string byte.
// Parsing skips blanks (space, codes 9 to 13), toggles the sign on each '-'
// of the sign run, then accumulates digits as acc * base_length + position
// until the first byte not in the alphabet. An invalid alphabet gives 0.
// Throughput: one byte per cycle while no end_of_string byte waits for the
// result slot. The figure is set by the accumulator loop: one 32 x 5
// multiply-add plus the 16-way symbol match per cycle.
// Path: a byte lands in the input register and is then folded into the parse
// state; folding an end_of_string byte also loads the result register, which
// drives result.valid.
// Reset: clears the configuration registers, the parse state and both
// pipeline valids. When the result receiver stalls, the result register
// holds; one more byte is taken into the input register, and ordinary
// bytes keep flowing, while an end_of_string byte waits for the result slot.
// ============================================================================
module string_to_int_any_base
    import s2i_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    s2i_cfg_if.sink         cfg,
    s2i_text_if.sink        text,
    s2i_result_if.source    result
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ALPHA_W-1:0] alpha_low_reg;
    logic [ALPHA_W-1:0] alpha_high_reg;
    logic [LEN_W-1:0]   base_len_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            base_len_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ALPHA_LOW:  alpha_low_reg  <= cfg.data;
                REG_ALPHA_HIGH: alpha_high_reg <= cfg.data;
                REG_BASE_LEN:   base_len_reg   <= cfg.data[LEN_W-1:0];
                default:        ;  // no register at this index
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_eos_reg;
    logic              out_valid_reg;
    logic              advance;

    // An end_of_string byte needs the result slot; other bytes never wait
    assign advance    = in_valid_reg && (!in_eos_reg || !out_valid_reg || result.ready);
    assign text.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            in_valid_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid)
        begin
            in_char_reg <= text.character;
            in_eos_reg  <= text.end_of_string;
        end
    end

    // ------------------------------------------------------------------
    // Alphabet symbols, lookup and validity
    // ------------------------------------------------------------------
    logic [2*ALPHA_W-1:0] alpha_all;
    logic [CHAR_W-1:0]    sym [MAX_SYMBOLS];
    logic [LEN_W-1:0]     used_len;
    logic                 hit;
    logic [SYM_W-1:0]     hit_pos;
    logic                 alpha_ok;

    assign alpha_all = {alpha_high_reg, alpha_low_reg};
    assign used_len  = (base_len_reg > LEN_W'(MAX_SYMBOLS)) ? LEN_W'(MAX_SYMBOLS)
                                                             : base_len_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            sym[i] = alpha_all[i*CHAR_W +: CHAR_W];
        end
    end

    // First matching position wins: scan downward so the lowest hit sticks
    always_comb
    begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--)
        begin
            if ((LEN_W'(i) < used_len) && (sym[i] == in_char_reg))
            begin
                hit     = 1'b1;
                hit_pos = SYM_W'(i);
            end
        end
    end

    // Radix in range, no forbidden byte, no symbol used twice
    always_comb
    begin
        alpha_ok = (base_len_reg >= LEN_W'(2)) && (base_len_reg <= LEN_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            if (LEN_W'(i) < base_len_reg)
            begin
                if ((sym[i] == CH_PLUS) || (sym[i] == CH_MINUS) || (sym[i] == CH_SPACE) ||
                    (sym[i] <= CH_CTRL_MAX) || (sym[i] >= CH_ASCII_TOP))
                begin
                    alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++)
                begin
                    if ((LEN_W'(j) < base_len_reg) && (sym[j] == sym[i]))
                    begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Parse state
    // ------------------------------------------------------------------
    phase_t              phase_reg;
    phase_t              phase_next;
    logic                neg_reg;
    logic                neg_next;
    logic [VALUE_W-1:0]  acc_reg;
    logic [VALUE_W-1:0]  acc_next;

    logic   is_blank;
    logic   in_signs;
    logic   in_digits;
    phase_t phase_step;
    logic                neg_step;
    logic [VALUE_W-1:0]  acc_step;

    assign is_blank = (in_char_reg == CH_SPACE) ||
                      ((in_char_reg >= CH_TAB) && (in_char_reg <= CH_CR));

    // Next phase: a byte can fall through blanks, signs and digits at once
    always_comb
    begin
        in_signs   = 1'b0;
        in_digits  = 1'b0;
        phase_step = phase_reg;
        if ((phase_step == PH_BLANKS) && !is_blank)
        begin
            phase_step = PH_SIGNS;
        end
        if (phase_step == PH_SIGNS)
        begin
            in_signs = 1'b1;
            if ((in_char_reg != CH_MINUS) && (in_char_reg != CH_PLUS))
            begin
                phase_step = PH_DIGITS;
            end
        end
        if (phase_step == PH_DIGITS)
        begin
            in_digits = 1'b1;
            if (!hit)
            begin
                phase_step = PH_STOP;
            end
        end
        phase_next = in_eos_reg ? PH_BLANKS : phase_step;
    end

    // Sign and accumulator update
    always_comb
    begin
        neg_step = neg_reg ^ (in_signs && (in_char_reg == CH_MINUS));
        acc_step = acc_reg;
        if (in_digits && hit)
        begin
            acc_step = acc_reg * VALUE_W'(base_len_reg) + VALUE_W'(hit_pos);
        end
        neg_next = in_eos_reg ? 1'b0 : neg_step;
        acc_next = in_eos_reg ? '0 : acc_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BLANKS;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                      out_valid_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      alpha_ok_reg;
    logic [VALUE_W-1:0]        signed_acc;
    logic                      emit;

    assign emit       = advance && in_eos_reg;
    assign signed_acc = neg_step ? (VALUE_W'(0) - acc_step) : acc_step;

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            value_reg    <= alpha_ok ? signed'(signed_acc) : '0;
            alpha_ok_reg <= alpha_ok;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.value          = value_reg;
    assign result.alphabet_valid = alpha_ok_reg;

endmodule

@@ design/s2i_checker.sv @@
// ============================================================================
// s2i_checker
// Port-level checks of the string to integer parser, bound to the top level.
// ============================================================================
module s2i_checker
    import s2i_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      text_valid,
    input logic                      text_ready,
    input logic                      text_eos,
    input logic                      result_valid,
    input logic                      result_ready,
    input logic signed [VALUE_W-1:0] result_value,
    input logic                      result_alpha_ok
);

    // Hold a stalled result beat
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid &&
        $stable(result_value) && $stable(result_alpha_ok))
        else $error("stalled result beat changed or dropped");

    // Force the value to zero for a rejected alphabet
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_alpha_ok |-> result_value == '0)
        else $error("nonzero value with invalid alphabet");

    // A fresh result follows an accepted end_of_string beat
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(text_valid && text_ready && text_eos, 2))
        else $error("result without matching end_of_string beat");

    // Keep accepting bytes while the result slot is free
    a_text_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid && $past(!result_valid) |-> text_ready)
        else $error("text stalled with free result slot");

endmodule

bind string_to_int_any_base s2i_checker u_s2i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .text_valid      (text.valid),
    .text_ready      (text.ready),
    .text_eos        (text.end_of_string),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_value    (result.value),
    .result_alpha_ok (result.alphabet_valid)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the any-base string to integer parser.
// ============================================================================
// Drives strings into the text channel and writes alphabets over the
// configuration channel. A bench-side copy of the parser folds every
// accepted byte and queues the number that each end_of_string byte should
// produce. A monitor pops that queue on every result beat and compares
// both fields. Source gaps and result stalls come in random bursts, and
// the last stretch of the run runs with neither.
// ============================================================================
module tb_top;
    import s2i_pkg::*;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      ok;
    } parse_result_t;

    logic clk;
    logic rst_n;

    s2i_cfg_if    cfg_bus ();
    s2i_text_if   text_bus ();
    s2i_result_if result_bus ();

    string_to_int_any_base uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .text   (text_bus),
        .result (result_bus)
    );

    // Bench copy of the configuration registers
    logic [ALPHA_W-1:0] alpha_lo_m = '0;
    logic [ALPHA_W-1:0] alpha_hi_m = '0;
    logic [LEN_W-1:0]   radix_m    = '0;

    // Bench copy of the parse state
    phase_t             phase_m    = PH_BLANKS;
    logic               neg_m      = 1'b0;
    logic [VALUE_W-1:0] acc_m      = '0;

    // Numbers still owed by the block, oldest first
    parse_result_t      expected_numbers [$];
    parse_result_t      head;

    logic [7:0]         syms [16];
    logic [7:0]         str_buf [$];
    bit                 idle_on    = 1'b1;
    int                 stall_left = 0;
    int                 sent_items = 0;
    int                 mismatch_count = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Hold a generous wall on the whole run
    initial
    begin
        #3000000;
        $display("string_to_int_any_base test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Bench parser
    // ------------------------------------------------------------------------

    // Symbol at a position of the configured alphabet
    function automatic logic [7:0] alpha_sym(input int p);
        logic [ALPHA_W-1:0] w;
        p = p & 15;
        w = (p < 8) ? alpha_lo_m : alpha_hi_m;
        return w[(p % 8) * 8 +: 8];
    endfunction

    // Radix in range, no forbidden symbol, no symbol twice
    function automatic bit alphabet_ok();
        int         n;
        logic [7:0] s;
        n = int'(radix_m);
        if (n < 2 || n > MAX_SYMBOLS)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            s = alpha_sym(i);
            if (s == CH_PLUS || s == CH_MINUS || s == CH_SPACE ||
                s <= CH_CTRL_MAX || s >= CH_ASCII_TOP)
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (alpha_sym(j) == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Fold one accepted byte; queue the number when it closes a string
    task automatic fold_char(input logic [7:0] ch, input logic eos);
        int            n;
        int            pos;
        bit            found;
        parse_result_t r;
        if (phase_m == PH_BLANKS && !(ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)))
            phase_m = PH_SIGNS;
        if (phase_m == PH_SIGNS)
        begin
            if (ch == CH_MINUS)
                neg_m = !neg_m;
            else if (ch != CH_PLUS)
                phase_m = PH_DIGITS;
        end
        if (phase_m == PH_DIGITS)
        begin
            // lookup only ever sees the first MAX_SYMBOLS symbols
            n = (int'(radix_m) > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(radix_m);
            found = 1'b0;
            pos = 0;
            // walk down so that the lowest matching position wins
            for (int i = n - 1; i >= 0; i--)
            begin
                if (alpha_sym(i) == ch)
                begin
                    found = 1'b1;
                    pos = i;
                end
            end
            if (found)
                acc_m = acc_m * 32'(radix_m) + 32'(pos);
            else
                phase_m = PH_STOP;
        end
        if (eos)
        begin
            r.ok    = alphabet_ok();
            r.value = r.ok ? (neg_m ? (32'd0 - acc_m) : acc_m) : '0;
            expected_numbers.push_back(r);
            phase_m = PH_BLANKS;
            neg_m   = 1'b0;
            acc_m   = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Stall the receiver in random bursts; drop any stall left
    // over once idling is switched off
    always @(negedge clk)
    begin
        if (!idle_on)
        begin
            stall_left <= 0;
            result_bus.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result_bus.ready <= 1'b0;
        end
        else if ($urandom_range(0, 11) == 0)
        begin
            stall_left <= $urandom_range(0, 18);
            result_bus.ready <= 1'b0;
        end
        else
        begin
            result_bus.ready <= 1'b1;
        end
    end

    // Compare every result beat with the oldest owed number
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (expected_numbers.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result beat: value %0d valid %0b",
                             result_bus.value, result_bus.alphabet_valid);
                mismatch_count++;
            end
            else
            begin
                head = expected_numbers.pop_front();
                if (result_bus.value !== head.value ||
                    result_bus.alphabet_valid !== head.ok)
                begin
                    if (mismatch_count < 10)
                        $display("mismatch: expected value %0d valid %0b, got value %0d valid %0b",
                                 head.value, head.ok,
                                 result_bus.value, result_bus.alphabet_valid);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Send one byte beat; leave valid high so the next byte can follow
    task automatic send_char(input logic [7:0] ch, input logic eos);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            text_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_bus.valid         <= 1'b1;
        text_bus.character     <= ch;
        text_bus.end_of_string <= eos;
        @(posedge clk);
        while (!text_bus.ready)
            @(posedge clk);
        fold_char(ch, eos);
        sent_items++;
        @(negedge clk);
    endtask

    // Send a literal string; its last byte closes it
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    // Send bytes lo..hi-1 of the string buffer
    task automatic send_range(input int lo, input int hi);
        for (int i = lo; i < hi; i++)
            send_char(str_buf[i], i == str_buf.size() - 1);
    endtask

    // Drop the text valid and wait until the block has nothing in flight
    task automatic settle();
        text_bus.valid <= 1'b0;
        while (expected_numbers.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [ALPHA_W-1:0] data);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (idx)
            REG_ALPHA_LOW:  alpha_lo_m = data;
            REG_ALPHA_HIGH: alpha_hi_m = data;
            REG_BASE_LEN:   radix_m    = data[LEN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Pack syms[] into the two alphabet words and write all three registers
    task automatic write_alphabet(input int len);
        logic [ALPHA_W-1:0] lo;
        logic [ALPHA_W-1:0] hi;
        for (int i = 0; i < 8; i++)
        begin
            lo[i * 8 +: 8] = syms[i];
            hi[i * 8 +: 8] = syms[i + 8];
        end
        write_reg(REG_ALPHA_LOW, lo);
        write_reg(REG_ALPHA_HIGH, hi);
        write_reg(REG_BASE_LEN, ALPHA_W'(len));
    endtask

    task automatic load_alphabet(input string s);
        for (int i = 0; i < 16; i++)
            syms[i] = (i < s.len()) ? s[i] : 8'h00;
        write_alphabet(s.len());
    endtask

    // Random alphabet: mostly valid, the rest broken in one way or fully random
    task automatic pick_alphabet();
        int         mode;
        int         len;
        int         k;
        bit         taken;
        logic [7:0] c;
        mode = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            len = $urandom_range(0, 1) ? 2 : 16;
        else
            len = $urandom_range(2, 16);
        for (int i = 0; i < 16; i++)
        begin
            do
            begin
                c = 8'($urandom_range(33, 127));
                taken = (c == CH_PLUS || c == CH_MINUS);
                for (int j = 0; j < i; j++)
                    if (syms[j] == c)
                        taken = 1'b1;
            end
            while (taken);
            syms[i] = c;
        end
        case (mode)
            6:
            begin
                // plant one forbidden symbol
                k = $urandom_range(0, len - 1);
                case ($urandom_range(0, 4))
                    0:       syms[k] = CH_PLUS;
                    1:       syms[k] = CH_MINUS;
                    2:       syms[k] = CH_SPACE;
                    3:       syms[k] = 8'($urandom_range(0, 31));
                    default: syms[k] = 8'($urandom_range(128, 255));
                endcase
            end
            7:
            begin
                // repeat an earlier symbol
                k = $urandom_range(1, len - 1);
                syms[k] = syms[$urandom_range(0, k - 1)];
            end
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       len = 0;
                    1:       len = 1;
                    2:       len = 17;
                    default: len = 31;
                endcase
            end
            9:
            begin
                for (int i = 0; i < 16; i++)
                    syms[i] = 8'($urandom);
                len = $urandom_range(0, 31);
            end
            default: ;
        endcase
        write_alphabet(len);
    endtask

    // Build one string: usually blanks, signs, digits and at times a stray tail byte
    task automatic make_string();
        int n;
        int nd;
        int pick;
        str_buf.delete();
        if ($urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 6))
                str_buf.push_back(8'($urandom));
        end
        else
        begin
            n = (radix_m == 0 || int'(radix_m) > 16) ? 16 : int'(radix_m);
            repeat ($urandom_range(0, 2))
            begin
                pick = $urandom_range(8, 13);
                str_buf.push_back((pick == 8) ? CH_SPACE : 8'(pick));
            end
            repeat ($urandom_range(0, 3))
                str_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            nd = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
            repeat (nd)
                str_buf.push_back(alpha_sym($urandom_range(0, n - 1)));
            if ($urandom_range(0, 2) == 0)
                str_buf.push_back(8'($urandom));
        end
        if (str_buf.size() == 0)
            str_buf.push_back(8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Blanks, sign runs, stop bytes, byte extremes and broken alphabets
    task automatic test_directed();
        load_alphabet("0123456789");
        send_char(CH_TAB, 1'b0);
        send_char(CH_CR, 1'b0);
        send_text("-42");
        send_text("+--7x3");        // digits after a stop byte are dropped
        send_char(8'hFF, 1'b1);     // top byte closes a string on its own
        send_char(8'h00, 1'b0);     // zero byte ends the digits at once
        send_text("5");
        send_text(" 5");
        settle();

        load_alphabet("0123456789abcdef");
        send_text("-ff");
        settle();

        load_alphabet("01");
        send_text("101");
        settle();

        // radix one above the symbol limit
        write_reg(REG_BASE_LEN, ALPHA_W'(MAX_SYMBOLS + 1));
        send_text("12");
        settle();

        // every byte 0xFF, widest radix code
        write_reg(REG_ALPHA_LOW, '1);
        write_reg(REG_ALPHA_HIGH, '1);
        write_reg(REG_BASE_LEN, ALPHA_W'((1 << LEN_W) - 1));
        send_char(8'hFF, 1'b0);
        send_char(8'hFF, 1'b1);
        settle();

        load_alphabet("0110");      // repeated symbol
        send_text("11");
        settle();

        write_reg(REG_BASE_LEN, '0);
        send_text("1");
        settle();
    endtask

    // Random strings over a fresh alphabet per phase
    task automatic test_random_strings(input int phases, input int per_phase,
                                       input bit allow_idle);
        int target;
        repeat (phases)
        begin
            pick_alphabet();
            idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            target = sent_items + per_phase;
            while (sent_items < target)
            begin
                make_string();
                send_range(0, str_buf.size());
            end
            settle();
        end
    endtask

    // Swap the alphabet while a string is half sent
    task automatic test_mid_string_config();
        int k;
        idle_on = 1'b1;
        repeat (8)
        begin
            pick_alphabet();
            make_string();
            k = (str_buf.size() > 1) ? $urandom_range(1, str_buf.size() - 1) : 0;
            send_range(0, k);
            settle();
            pick_alphabet();
            send_range(k, str_buf.size());
            settle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = REG_ALPHA_LOW;
        cfg_bus.data           = '0;
        text_bus.valid         = 1'b0;
        text_bus.character     = '0;
        text_bus.end_of_string = 1'b0;
        result_bus.ready       = 1'b0;
        rst_n                  = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random_strings(8, 85, 1'b1);
        test_mid_string_config();
        // last stretch: no gaps, no stalls
        test_random_strings(1, 120, 1'b0);

        while (expected_numbers.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && expected_numbers.size() == 0)
            $display("string_to_int_any_base test passed");
        else
            $display("string_to_int_any_base test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/s2i_pkg.sv
design/s2i_if.sv
design/string_to_int_any_base.sv
design/s2i_checker.sv
tb/tb_top.sv
